/* rtl/core/adsr_pkg.sv */
// Shared constants, register indexes and queue entry flags for the ADSR envelope level block.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package adsr_pkg;

    localparam int TIME_BITS_DEF   = 32;
    localparam int LEVEL_BITS_DEF  = 16;
    localparam int DUR_BITS        = 24;
    localparam int CFG_LEVEL_BITS  = 16;
    localparam int CFG_DATA_BITS   = 32;
    localparam int ADDR_BITS       = 5;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [DUR_BITS-1:0]       ATTACK_RESET  = 24'd4800;
    localparam logic [DUR_BITS-1:0]       DECAY_RESET   = 24'd4800;
    localparam logic [DUR_BITS-1:0]       RELEASE_RESET = 24'd9600;
    localparam logic [CFG_LEVEL_BITS-1:0] SUSTAIN_RESET = 16'd32768;
    localparam logic [CFG_LEVEL_BITS-1:0] START_RESET   = 16'd32768;

    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_RELEASE = 3'd2,
        REG_SUSTAIN = 3'd3,
        REG_START   = 3'd4
    } reg_idx_t;

    // zero: level forced to 0; rel: note off, release ramp applies;
    // div: curve level needs a divide; neg: decay runs downward
    typedef struct packed {
        logic zero;
        logic rel;
        logic div;
        logic neg;
    } ent_flags_t;

endpackage

`default_nettype wire

/* rtl/core/adsr_envelope_level.sv */
// Linear ADSR envelope level. Beats pass the front end stages and the queue; the back
// end then runs the curve and release divides (both, one or none) on the shared
// one-bit-per-cycle mul/div unit, one queue entry at a time.
// Front end and queue keep taking beats while a divide runs, until the queue fills. Reset
// clears all control state and loads the register defaults; no clearing pass.
`default_nettype none

module adsr_envelope_level #(
    parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [adsr_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [adsr_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic [TIME_BITS-1:0]               now_time,
    input  wire logic [TIME_BITS-1:0]               on_time,
    input  wire logic [TIME_BITS-1:0]               off_time,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic      [LEVEL_BITS-1:0]              level,
    output logic                                    silent
);

    localparam int DW  = adsr_pkg::DUR_BITS;
    localparam int CLB = adsr_pkg::CFG_LEVEL_BITS;
    localparam int DB  = adsr_pkg::CFG_DATA_BITS;
    localparam int LW  = (LEVEL_BITS > CLB) ? LEVEL_BITS : CLB;
    localparam int EW  = $bits(adsr_pkg::ent_flags_t) + 2 * LEVEL_BITS + 3 * DW;
    localparam logic [LW-1:0] FULL_W = LW'(1) << (LEVEL_BITS - 1);

    logic [DW-1:0]  attack_reg;
    logic [DW-1:0]  decay_reg;
    logic [DW-1:0]  release_reg;
    logic [CLB-1:0] sustain_reg;
    logic [CLB-1:0] start_reg;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic [DW-1:0]         attack_fix;
    logic [DW-1:0]         decay_fix;
    logic [DW-1:0]         release_fix;
    logic [LW-1:0]         sustain_w;
    logic [LW-1:0]         start_w;
    logic [LEVEL_BITS-1:0] sustain_fix;
    logic [LEVEL_BITS-1:0] start_fix;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [EW-1:0] q_wdata;
    logic [EW-1:0] q_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[adsr_pkg::ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= adsr_pkg::ATTACK_RESET;
            decay_reg   <= adsr_pkg::DECAY_RESET;
            release_reg <= adsr_pkg::RELEASE_RESET;
            sustain_reg <= adsr_pkg::SUSTAIN_RESET;
            start_reg   <= adsr_pkg::START_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                adsr_pkg::REG_ATTACK:  attack_reg  <= pwdata[DW-1:0];
                adsr_pkg::REG_DECAY:   decay_reg   <= pwdata[DW-1:0];
                adsr_pkg::REG_RELEASE: release_reg <= pwdata[DW-1:0];
                adsr_pkg::REG_SUSTAIN: sustain_reg <= pwdata[CLB-1:0];
                adsr_pkg::REG_START:   start_reg   <= pwdata[CLB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            adsr_pkg::REG_ATTACK:  prdata = DB'(attack_reg);
            adsr_pkg::REG_DECAY:   prdata = DB'(decay_reg);
            adsr_pkg::REG_RELEASE: prdata = DB'(release_reg);
            adsr_pkg::REG_SUSTAIN: prdata = DB'(sustain_reg);
            adsr_pkg::REG_START:   prdata = DB'(start_reg);
            default:               prdata = '0;
        endcase
    end

    // zero durations count as one tick, levels clamp to full scale
    assign attack_fix  = (attack_reg == '0) ? DW'(1) : attack_reg;
    assign decay_fix   = (decay_reg == '0) ? DW'(1) : decay_reg;
    assign release_fix = (release_reg == '0) ? DW'(1) : release_reg;
    assign sustain_w   = LW'(sustain_reg);
    assign start_w     = LW'(start_reg);
    assign sustain_fix = (sustain_w > FULL_W) ? FULL_W[LEVEL_BITS-1:0]
                                              : sustain_w[LEVEL_BITS-1:0];
    assign start_fix   = (start_w > FULL_W) ? FULL_W[LEVEL_BITS-1:0]
                                            : start_w[LEVEL_BITS-1:0];

    adsr_front #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS),
        .ENT_BITS   (EW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .now_time    (now_time),
        .on_time     (on_time),
        .off_time    (off_time),
        .attack_fix  (attack_fix),
        .decay_fix   (decay_fix),
        .release_fix (release_fix),
        .start_fix   (start_fix),
        .sustain_fix (sustain_fix),
        .queue_full  (q_full),
        .queue_push  (q_push),
        .queue_entry (q_wdata)
    );

    adsr_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    adsr_back #(
        .LEVEL_BITS (LEVEL_BITS),
        .ENT_BITS   (EW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (q_empty),
        .queue_entry  (q_rdata),
        .queue_pop    (q_pop),
        .release_fix  (release_fix),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .level        (level),
        .silent       (silent)
    );

endmodule

`default_nettype wire

/* rtl/core/adsr_fifo.sv */
// Short register queue between the classify front end and the divide back end.
// Depends on adsr_pkg for the queue depth.
`default_nettype none

module adsr_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int DEPTH = adsr_pkg::QUEUE_DEPTH;
    localparam int PTRW  = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW:0]    count_reg;

    assign full  = (count_reg == (PTRW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adsr_front.sv */
// Front end: accepts input beats, finds lifetime and release time, classifies the
// envelope phase and packs divide operands into a queue entry. Depends on adsr_pkg.
`default_nettype none

module adsr_front #(
    parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF,
    parameter int ENT_BITS   = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [TIME_BITS-1:0]          now_time,
    input  wire logic [TIME_BITS-1:0]          on_time,
    input  wire logic [TIME_BITS-1:0]          off_time,
    input  wire logic [adsr_pkg::DUR_BITS-1:0] attack_fix,
    input  wire logic [adsr_pkg::DUR_BITS-1:0] decay_fix,
    input  wire logic [adsr_pkg::DUR_BITS-1:0] release_fix,
    input  wire logic [LEVEL_BITS-1:0]         start_fix,
    input  wire logic [LEVEL_BITS-1:0]         sustain_fix,
    input  wire logic                          queue_full,
    output logic                               queue_push,
    output logic [ENT_BITS-1:0]                queue_entry
);

    localparam int DW = adsr_pkg::DUR_BITS;
    localparam int CW = (TIME_BITS > DW) ? TIME_BITS : DW + 1;

    // stage 1
    logic                 v1_reg;
    logic                 on1_reg;
    logic                 early1_reg;
    logic [TIME_BITS-1:0] life1_reg;
    logic [TIME_BITS-1:0] elap1_reg;

    // stage 2
    logic                 v2_reg;
    logic [ENT_BITS-1:0]  ent2_reg;

    logic                 adv1;
    logic                 adv2;
    logic                 take;
    logic                 note_on;
    logic [TIME_BITS-1:0] life_next;
    logic [TIME_BITS-1:0] elap_next;

    logic [CW-1:0]         life_w;
    logic [CW-1:0]         elap_w;
    logic [CW-1:0]         a_w;
    logic [CW-1:0]         ad_w;
    logic [CW-1:0]         t_w;
    logic                  in_attack;
    logic                  in_decay;
    logic                  sus_below;
    adsr_pkg::ent_flags_t  flags;
    logic [LEVEL_BITS-1:0] base;
    logic [LEVEL_BITS-1:0] y_op;
    logic [DW-1:0]         x_op;
    logic [DW-1:0]         d_op;
    logic [ENT_BITS-1:0]   ent_next;

    assign adv2       = !v2_reg || !queue_full;
    assign adv1       = !v1_reg || adv2;
    assign item_stall = !adv1;
    assign take       = item_valid && adv1;
    assign queue_push = v2_reg && !queue_full;
    assign queue_entry = ent2_reg;

    assign note_on   = on_time > off_time;
    assign life_next = note_on ? now_time - on_time : off_time - on_time;
    assign elap_next = (now_time > off_time) ? now_time - off_time : '0;

    assign life_w    = CW'(life1_reg);
    assign elap_w    = CW'(elap1_reg);
    assign a_w       = CW'(attack_fix);
    assign ad_w      = CW'(attack_fix) + CW'(decay_fix);
    assign t_w       = life_w - a_w;
    assign in_attack = life_w <= a_w;
    assign in_decay  = !in_attack && (life_w <= ad_w);
    assign sus_below = sustain_fix < start_fix;

    always_comb
    begin
        flags.zero = (on1_reg && early1_reg) ||
                     (!on1_reg && (elap_w >= CW'(release_fix)));
        flags.rel  = !on1_reg;
        flags.div  = in_attack || in_decay;
        flags.neg  = 1'b0;
        base       = sustain_fix;
        y_op       = start_fix;
        x_op       = life_w[DW-1:0];
        d_op       = attack_fix;
        if (in_attack)
        begin
            base = '0;
        end
        else if (in_decay)
        begin
            flags.neg = sus_below;
            base      = start_fix;
            y_op      = sus_below ? start_fix - sustain_fix : sustain_fix - start_fix;
            x_op      = t_w[DW-1:0];
            d_op      = decay_fix;
        end
        ent_next = {flags, base, y_op, x_op, d_op, elap_w[DW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= take;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            on1_reg    <= note_on;
            early1_reg <= now_time < on_time;
            life1_reg  <= life_next;
            elap1_reg  <= elap_next;
        end
        if (adv2 && v1_reg)
        begin
            ent2_reg <= ent_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adsr_muldiv.sv */
// Multiply then restoring divide: q = (x * y) / d with x <= d, one quotient bit per cycle.
// Depends on adsr_pkg for the duration width.
`default_nettype none

module adsr_muldiv #(
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [adsr_pkg::DUR_BITS-1:0] x,
    input  wire logic [LEVEL_BITS-1:0]         y,
    input  wire logic [adsr_pkg::DUR_BITS-1:0] d,
    output logic                               busy,
    output logic                               done,
    output logic [LEVEL_BITS-1:0]              q
);

    localparam int DW   = adsr_pkg::DUR_BITS;
    localparam int PW   = DW + LEVEL_BITS;
    localparam int CNTW = $clog2(LEVEL_BITS);

    typedef enum logic {
        M_IDLE,
        M_DIV
    } mstate_t;

    mstate_t               state_reg;
    logic                  done_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [DW-1:0]         rem_reg;
    logic [LEVEL_BITS-1:0] quo_reg;
    logic [DW-1:0]         d_reg;

    logic [PW-1:0]         prod;
    logic [DW:0]           trial;
    logic [DW:0]           diff;
    logic                  fits;
    logic                  done_next;

    assign prod  = PW'(x) * PW'(y);
    assign trial = {rem_reg, quo_reg[LEVEL_BITS-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};

    assign done_next = (state_reg == M_DIV) && (cnt_reg == CNTW'(LEVEL_BITS - 1));

    assign busy = (state_reg != M_IDLE);
    assign done = done_reg;
    assign q    = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= done_next;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= prod[PW-1:LEVEL_BITS];
                        quo_reg   <= prod[LEVEL_BITS-1:0];
                        d_reg     <= d;
                        cnt_reg   <= '0;
                        state_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
                    quo_reg <= {quo_reg[LEVEL_BITS-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(LEVEL_BITS - 1))
                    begin
                        state_reg <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adsr_back.sv */
// Back end: pops queue entries, runs the curve and release divides on the shared
// mul/div unit and holds the output register. Depends on adsr_pkg and adsr_muldiv.
`default_nettype none

module adsr_back #(
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF,
    parameter int ENT_BITS   = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          queue_empty,
    input  wire logic [ENT_BITS-1:0]           queue_entry,
    output logic                               queue_pop,
    input  wire logic [adsr_pkg::DUR_BITS-1:0] release_fix,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [LEVEL_BITS-1:0]              level,
    output logic                               silent
);

    localparam int DW = adsr_pkg::DUR_BITS;
    localparam logic [LEVEL_BITS-1:0] FULL = LEVEL_BITS'(1) << (LEVEL_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT_CURVE,
        ST_WAIT_REL,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [ENT_BITS-1:0]   ent_reg;
    logic                  start_reg;
    logic [DW-1:0]         mx_reg;
    logic [LEVEL_BITS-1:0] my_reg;
    logic [DW-1:0]         md_reg;
    logic [LEVEL_BITS-1:0] reach_reg;
    logic [LEVEL_BITS-1:0] res_reg;
    logic                  result_valid_reg;
    logic [LEVEL_BITS-1:0] level_reg;
    logic                  silent_reg;

    adsr_pkg::ent_flags_t  e_flags;
    logic [LEVEL_BITS-1:0] e_base;
    logic [LEVEL_BITS-1:0] e_y;
    logic [DW-1:0]         e_x;
    logic [DW-1:0]         e_d;
    logic [DW-1:0]         e_elap;
    logic                  mul_busy;
    logic                  mul_done;
    logic [LEVEL_BITS-1:0] mul_q;
    logic [LEVEL_BITS-1:0] curve_lvl;
    logic                  start_next;
    logic                  result_valid_next;

    assign {e_flags, e_base, e_y, e_x, e_d, e_elap} = ent_reg;

    assign queue_pop    = (state_reg == ST_IDLE) && !queue_empty;
    assign curve_lvl    = e_flags.neg ? e_base - mul_q : e_base + mul_q;
    assign result_valid = result_valid_reg;
    assign level        = level_reg;
    assign silent       = silent_reg;

    assign start_next = ((state_reg == ST_LOAD) && !e_flags.zero &&
                         (e_flags.div || e_flags.rel)) ||
                        ((state_reg == ST_WAIT_CURVE) && mul_done && e_flags.rel);
    assign result_valid_next = (state_reg == ST_OUT) || (result_valid_reg && result_stall);

    adsr_muldiv #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .x     (mx_reg),
        .y     (my_reg),
        .d     (md_reg),
        .busy  (mul_busy),
        .done  (mul_done),
        .q     (mul_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            start_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg        <= start_next;
            result_valid_reg <= result_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        ent_reg   <= queue_entry;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    priority if (e_flags.zero)
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else if (e_flags.div)
                    begin
                        mx_reg    <= e_x;
                        my_reg    <= e_y;
                        md_reg    <= e_d;
                        state_reg <= ST_WAIT_CURVE;
                    end
                    else if (e_flags.rel)
                    begin
                        reach_reg <= e_base;
                        mx_reg    <= e_elap;
                        my_reg    <= e_base;
                        md_reg    <= release_fix;
                        state_reg <= ST_WAIT_REL;
                    end
                    else
                    begin
                        res_reg   <= e_base;
                        state_reg <= ST_OUT;
                    end
                end
                ST_WAIT_CURVE:
                begin
                    if (mul_done)
                    begin
                        if (e_flags.rel)
                        begin
                            reach_reg <= curve_lvl;
                            mx_reg    <= e_elap;
                            my_reg    <= curve_lvl;
                            md_reg    <= release_fix;
                            state_reg <= ST_WAIT_REL;
                        end
                        else
                        begin
                            res_reg   <= curve_lvl;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_WAIT_REL:
                begin
                    if (mul_done)
                    begin
                        res_reg   <= reach_reg - mul_q;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        level_reg  <= res_reg;
                        silent_reg <= (res_reg == '0);
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !mul_busy)
        else $error("mul/div started while busy");

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_WAIT_CURVE || state_reg == ST_WAIT_REL))
        else $error("mul/div result with no divide pending");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (level_reg <= FULL))
        else $error("level above full scale");

    a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
        queue_pop |=> !queue_pop)
        else $error("two entries popped back to back");

endmodule

`default_nettype wire

/* bench/tb_adsr_envelope_level.sv */
`timescale 1ns / 1ps
// Testbench for adsr_envelope_level: directed and random beats over several envelope settings,
// results checked against an in-bench envelope predictor. Depends on adsr_pkg and the RTL only.

class envelope_scoreboard;
    localparam longint unsigned FULL_SCALE = 64'd1 << (adsr_pkg::LEVEL_BITS_DEF - 1);

    typedef struct packed {
        bit [15:0] level;
        bit        silent;
    } level_beat_t;

    bit [23:0]   attack_q;
    bit [23:0]   decay_q;
    bit [23:0]   release_q;
    bit [15:0]   sustain_q;
    bit [15:0]   start_q;
    level_beat_t expected_q[$];
    int unsigned errors;

    function new();
        attack_q  = adsr_pkg::ATTACK_RESET;
        decay_q   = adsr_pkg::DECAY_RESET;
        release_q = adsr_pkg::RELEASE_RESET;
        sustain_q = adsr_pkg::SUSTAIN_RESET;
        start_q   = adsr_pkg::START_RESET;
        errors    = 0;
    endfunction

    function void write_reg(bit [adsr_pkg::ADDR_BITS-1:0] addr, bit [31:0] data);
        case (addr[4:2])
            adsr_pkg::REG_ATTACK:  attack_q  = data[23:0];
            adsr_pkg::REG_DECAY:   decay_q   = data[23:0];
            adsr_pkg::REG_RELEASE: release_q = data[23:0];
            adsr_pkg::REG_SUSTAIN: sustain_q = data[15:0];
            adsr_pkg::REG_START:   start_q   = data[15:0];
            default: ;
        endcase
    endfunction

    function longint unsigned dur_eff(bit [23:0] v);
        return (v == 0) ? 64'd1 : 64'(v);
    endfunction

    function longint unsigned lvl_eff(bit [15:0] v);
        return (64'(v) > FULL_SCALE) ? FULL_SCALE : 64'(v);
    endfunction

    // attack / decay / sustain curve at a non-negative note lifetime
    function longint unsigned curve_at(longint unsigned life);
        longint unsigned a;
        longint unsigned d;
        longint unsigned p;
        longint unsigned s;
        longint unsigned t;
        a = dur_eff(attack_q);
        d = dur_eff(decay_q);
        p = lvl_eff(start_q);
        s = lvl_eff(sustain_q);
        if (life <= a)
            return (life * p) / a;
        t = life - a;
        if (t <= d) begin
            if (s >= p)
                return p + (t * (s - p)) / d;
            return p - (t * (p - s)) / d;
        end
        return s;
    endfunction

    function void note_input(bit [31:0] now_t, bit [31:0] on_t, bit [31:0] off_t);
        longint unsigned lvl;
        longint unsigned reached;
        longint unsigned rel;
        longint unsigned elapsed;
        level_beat_t     beat;
        if (on_t > off_t) begin
            lvl = (now_t < on_t) ? 64'd0 : curve_at(64'(now_t - on_t));
        end
        else begin
            reached = curve_at(64'(off_t - on_t));
            rel     = dur_eff(release_q);
            elapsed = (now_t > off_t) ? 64'(now_t - off_t) : 64'd0;
            lvl     = (elapsed >= rel) ? 64'd0 : reached - (elapsed * reached) / rel;
        end
        if (lvl > FULL_SCALE)
            lvl = FULL_SCALE;
        beat.level  = lvl[15:0];
        beat.silent = (lvl == 0);
        expected_q.push_back(beat);
    endfunction

    function void check_result(bit [15:0] lvl, bit sil);
        level_beat_t exp_beat;
        if (expected_q.size() == 0) begin
            if (errors < 10)
                $display("unexpected result beat: level %0d silent %0b", lvl, sil);
            errors++;
            return;
        end
        exp_beat = expected_q.pop_front();
        if (exp_beat.level !== lvl || exp_beat.silent !== sil) begin
            if (errors < 10)
                $display("mismatch: level exp %0d got %0d, silent exp %0b got %0b",
                         exp_beat.level, lvl, exp_beat.silent, sil);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_adsr_envelope_level;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int NUM_REGS       = 5;
    localparam int NUM_PHASES     = 16;
    localparam int FIRST_ITEMS    = 105;
    localparam int PHASE_ITEMS    = 122;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ADDR_W         = adsr_pkg::ADDR_BITS;
    localparam int DATA_W         = adsr_pkg::CFG_DATA_BITS;
    localparam logic [31:0] TMAX  = 32'hFFFF_FFFF;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    logic [31:0]       now_time     = '0;
    logic [31:0]       on_time      = '0;
    logic [31:0]       off_time     = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [15:0]       level;
    logic              silent;

    envelope_scoreboard sb = new();

    int unsigned cyc_count    = 0;
    bit [1:0]    stall_mode   = 2'd0;
    int unsigned quiet_cycles = 0;

    adsr_envelope_level dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .now_time     (now_time),
        .on_time      (on_time),
        .off_time     (off_time),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .level        (level),
        .silent       (silent)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // result side stall pattern, from one of four randomly chosen modes
    always @(posedge clk)
    begin
        cyc_count <= cyc_count + 1;
        if (cyc_count % 256 == 0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    result_stall <= 1'b0;
            2'd1:    result_stall <= ($urandom_range(0, 9) < 4);
            2'd2:    result_stall <= (cyc_count % 11) < 8;
            default: result_stall <= (cyc_count % 32) < 20;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(level, silent);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(addr, data);
        @(posedge clk);
    endtask

    task automatic apply_envelope(input logic [31:0] a, input logic [31:0] d,
                                  input logic [31:0] r, input logic [31:0] s,
                                  input logic [31:0] p);
        apb_write({adsr_pkg::REG_ATTACK, 2'b00}, a);
        apb_write({adsr_pkg::REG_DECAY, 2'b00}, d);
        apb_write({adsr_pkg::REG_RELEASE, 2'b00}, r);
        apb_write({adsr_pkg::REG_SUSTAIN, 2'b00}, s);
        apb_write({adsr_pkg::REG_START, 2'b00}, p);
    endtask

    function automatic logic [31:0] rand_dur();
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0:       v = 24'd0;
            1:       v = 24'hFF_FFFF;
            2:       v = 24'($urandom);
            default: v = 24'($urandom_range(1, 200));
        endcase
        return {8'($urandom), v};
    endfunction

    function automatic logic [31:0] rand_lvl();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'd0;
            1:       v = 16'd32768;
            2:       v = 16'($urandom_range(32769, 65535));
            default: v = 16'($urandom_range(0, 32768));
        endcase
        return {16'($urandom), v};
    endfunction

    task automatic send_beat(input logic [31:0] n, input logic [31:0] o, input logic [31:0] f);
        item_valid <= 1'b1;
        now_time   <= n;
        on_time    <= o;
        off_time   <= f;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_input(n, o, f);
    endtask

    task automatic pause_beats(input int n);
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly note-on and note-off sequences timed around the current envelope
    function automatic void make_times(output logic [31:0] n, output logic [31:0] o,
                                       output logic [31:0] f);
        longint unsigned span;
        longint unsigned rel_span;
        int unsigned     k;
        span     = sb.dur_eff(sb.attack_q) + sb.dur_eff(sb.decay_q);
        span     = span + span / 4 + 2;
        rel_span = sb.dur_eff(sb.release_q);
        rel_span = rel_span + rel_span / 4 + 2;
        k = $urandom_range(0, 99);
        n = $urandom;
        o = $urandom;
        f = $urandom;
        if (k < 40)
        begin
            if (o == 0)
                o = 32'd1;
            f = $urandom_range(0, o - 1);
            n = o + $urandom_range(0, 32'(span));
        end
        else if (k < 80)
        begin
            f = o + $urandom_range(0, 32'(span));
            n = f + $urandom_range(0, 32'(rel_span));
        end
        else if (k < 88)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (o == 0)
                        o = 32'd1;
                    f = $urandom_range(0, o - 1);
                    n = o - $urandom_range(1, 1000);
                end
                1:
                begin
                    f = o + $urandom_range(0, 32'(span));
                    n = f - $urandom_range(1, 1000);
                end
                default:
                begin
                    f = o;
                    n = o + $urandom_range(0, 32'(rel_span));
                end
            endcase
        end
    endfunction

    task automatic drive_random(input int count);
        int          burst_left;
        logic [31:0] n;
        logic [31:0] o;
        logic [31:0] f;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    pause_beats($urandom_range(1, 15));
            end
            burst_left--;
            if ($urandom_range(0, 249) == 0)
            begin
                pause_beats(1);
                drain_results();
            end
            make_times(n, o, f);
            send_beat(n, o, f);
        end
    endtask

    task automatic quiesce();
        pause_beats(1);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset envelope: attack 4800, decay 4800, release 9600, full-scale levels
        send_beat(32'd0, 32'd0, 32'd0);
        send_beat(TMAX, TMAX, TMAX);
        send_beat(32'd2401, 32'd1, 32'd0);
        send_beat(32'd4801, 32'd1, 32'd0);
        send_beat(32'd7201, 32'd1, 32'd0);
        send_beat(32'd20000, 32'd1, 32'd0);
        send_beat(TMAX, 32'd1, 32'd0);
        send_beat(32'd500, 32'd1000, 32'd0);
        send_beat(32'd0, TMAX, TMAX - 1);
        send_beat(TMAX, TMAX, 32'd0);
        send_beat(32'd6000, 32'd0, 32'd2400);
        send_beat(32'd11999, 32'd0, 32'd2400);
        send_beat(32'd12000, 32'd0, 32'd2400);
        send_beat(32'd1000, 32'd0, 32'd2400);
        send_beat(TMAX, 32'd0, TMAX);
        send_beat(TMAX, 32'd0, 32'd0);
        send_beat(32'd5000, 32'd2000, 32'd2000);
        drive_random(FIRST_ITEMS);

        for (int ph = 1; ph < NUM_PHASES; ph++)
        begin
            quiesce();
            case (ph)
                1: apply_envelope(32'd10, 32'd20, 32'd30, 32'd8000, 32'd30000);
                2: apply_envelope(32'd0, 32'd0, 32'd0, 32'd65535, 32'd40000);
                3: apply_envelope(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'd0, 32'd32768);
                4: apply_envelope(32'd1, 32'd1, 32'd1, 32'd32768, 32'd0);
                5: apply_envelope(32'd100, 32'd50, 32'd200, 32'd0, 32'd0);
                default:
                begin
                    apply_envelope(rand_dur(), rand_dur(), rand_dur(), rand_lvl(), rand_lvl());
                    // unmapped register slot, must leave the envelope unchanged
                    apb_write(ADDR_W'((NUM_REGS + $urandom_range(0, 2)) * 4), $urandom);
                end
            endcase
            drive_random(PHASE_ITEMS);
        end

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
